// ===== design/shp_pkg.sv =====
`timescale 1ns / 1ps

package shp_pkg;

  // table geometry
  localparam int unsigned SLOTS         = 1024;
  localparam int unsigned SLOT_AW       = 10;
  localparam int unsigned MAX_KEY_BYTES = 64;
  localparam int unsigned KEY_AW        = 6;
  localparam int unsigned LEN_W         = 7;
  localparam int unsigned CNT_W         = 11;
  localparam int unsigned LG_W          = 4;
  localparam int unsigned KBUF_AW       = KEY_AW + 1;
  localparam int unsigned KBUF_DEPTH    = 2 * MAX_KEY_BYTES;
  localparam int unsigned SBYTES_AW     = SLOT_AW + KEY_AW;
  localparam int unsigned SBYTES_DEPTH  = SLOTS * MAX_KEY_BYTES;
  localparam int unsigned META_W        = LEN_W + 1;

  // capacity limits
  localparam logic [LG_W-1:0] LG_MIN   = 4'd1;
  localparam logic [LG_W-1:0] LG_MAX   = 4'd10;
  localparam logic [LG_W-1:0] LG_RESET = 4'd10;

  // fnv-1a constants
  localparam logic [31:0] HASH_BASIS = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME = 32'd16777619;

  // operation codes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // command passed from front to back
  typedef struct packed {
    logic              clear;
    logic              lookup;
    logic              too_long;
    logic              bank;
    logic [LEN_W-1:0]  len;
    logic [31:0]       hash;
  } cmd_t;

  // key buffer bank handed back by the back end
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic             found;
    logic             inserted;
    logic             duplicate;
    logic             table_full;
    logic             key_too_long;
    logic [CNT_W-1:0] key_count;
  } res_t;

  typedef enum logic [2:0] {
    B_INIT,
    B_IDLE,
    B_SWEEP,
    B_META,
    B_CHECK,
    B_CMP,
    B_COPY,
    B_RESULT
  } back_state_e;

endpackage

// ===== design/shp_if.sv =====
`timescale 1ns / 1ps

interface shp_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] key_byte;
  logic       last;
  modport source (output valid, output mode, output key_byte, output last, input ready);
  modport sink (input valid, input mode, input key_byte, input last, output ready);
endinterface

interface shp_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic        inserted;
  logic        duplicate;
  logic        table_full;
  logic        key_too_long;
  logic [10:0] key_count;
  modport source (output valid, output found, output inserted, output duplicate,
                  output table_full, output key_too_long, output key_count, input ready);
  modport sink (input valid, input found, input inserted, input duplicate,
                input table_full, input key_too_long, input key_count, output ready);
endinterface

interface shp_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] log2_capacity;
  modport source (output valid, output log2_capacity, input ready);
  modport sink (input valid, input log2_capacity, output ready);
endinterface

// ===== design/string_hash_set_probe_core.sv =====
`timescale 1ns / 1ps

// Set of short byte-string keys in an open-addressing table (fnv-1a hash,
// linear probing). Keys enter on req_i one byte per transfer, the final byte
// flagged by last; mode selects insert, lookup or clear. One result leaves on
// rsp_o per final key byte and per clear. cfg_i writes log2_capacity; the user
// must do so only while the block is idle; the block itself does not enforce it.
// Key bytes are taken one per cycle, while req_i.ready is high, into one of
// two key buffer banks. The probe engine then walks slots: a metadata read
// and check for each slot visited, a byte-by-byte compare for each slot whose
// length matches and a byte copy on insert, plus command and result handling.
// A clear sweeps all 1024 metadata entries, one entry per cycle.
// After reset all 1024 metadata entries are swept; req_i.ready stays
// low until then. A result waiting on a stalled receiver holds the probe
// engine, while the front keeps taking bytes until both key banks or the
// two-entry command queue are occupied.
module string_hash_set_probe_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  shp_req_if.sink   req_i,
  shp_rsp_if.source rsp_o,
  shp_cfg_if.sink   cfg_i
);

  logic [shp_pkg::LG_W-1:0]    lg_q, lg_d;
  logic                        init_done;
  shp_pkg::cmd_t               push_cmd;
  shp_pkg::cmd_t               head_cmd;
  logic                        cmd_push;
  logic                        cmd_pop;
  shp_pkg::fifo_stat_t         fifo_stat;
  shp_pkg::rel_t               rel;
  logic                        kbuf_we;
  logic [shp_pkg::KBUF_AW-1:0] kbuf_waddr;
  logic [7:0]                  kbuf_wdata;
  logic [shp_pkg::KBUF_AW-1:0] kbuf_raddr;
  logic [7:0]                  kbuf_rdata;

  // capacity register
  assign cfg_i.ready = 1'b1;
  assign lg_d = (cfg_i.valid && cfg_i.ready) ? cfg_i.log2_capacity : lg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_q <= shp_pkg::LG_RESET;
    end else begin
      lg_q <= lg_d;
    end
  end

  shp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .init_done_i  (init_done),
    .req          (req_i),
    .fifo_full_i  (fifo_stat.full),
    .rel_i        (rel),
    .cmd_o        (push_cmd),
    .cmd_push_o   (cmd_push),
    .kbuf_we_o    (kbuf_we),
    .kbuf_waddr_o (kbuf_waddr),
    .kbuf_wdata_o (kbuf_wdata)
  );

  // two banks of key bytes
  shp_ram #(
    .WIDTH (8),
    .DEPTH (shp_pkg::KBUF_DEPTH)
  ) u_kbuf_ram (
    .clk_i   (clk_i),
    .we_i    (kbuf_we),
    .waddr_i (kbuf_waddr),
    .wdata_i (kbuf_wdata),
    .raddr_i (kbuf_raddr),
    .rdata_o (kbuf_rdata)
  );

  shp_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .cmd_i  (push_cmd),
    .pop_i  (cmd_pop),
    .cmd_o  (head_cmd),
    .stat_o (fifo_stat)
  );

  shp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .log2_cap_i   (lg_q),
    .cmd_i        (head_cmd),
    .fifo_empty_i (fifo_stat.empty),
    .pop_o        (cmd_pop),
    .rel_o        (rel),
    .init_done_o  (init_done),
    .kbuf_raddr_o (kbuf_raddr),
    .kbuf_rdata_i (kbuf_rdata),
    .rsp          (rsp_o)
  );

  // no byte is taken before the metadata sweep ends
  a_ready_after_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> init_done)
    else $error("input ready before metadata sweep finished");

  // a command is never pushed into a full queue
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> !fifo_stat.full)
    else $error("command pushed into full queue");

  // at most one outcome flag per result
  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> $onehot0({rsp_o.found, rsp_o.inserted, rsp_o.duplicate,
                              rsp_o.table_full, rsp_o.key_too_long}))
    else $error("more than one outcome flag set");

  // a fresh insert always leaves a nonzero count
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.inserted |-> rsp_o.key_count != '0)
    else $error("insert reported with zero key count");

endmodule

// ===== design/shp_ram.sv =====
`timescale 1ns / 1ps

module shp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/shp_cmd_fifo.sv =====
`timescale 1ns / 1ps

module shp_cmd_fifo (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  shp_pkg::cmd_t            cmd_i,
  input  logic                     pop_i,
  output shp_pkg::cmd_t            cmd_o,
  output shp_pkg::fifo_stat_t      stat_o
);

  shp_pkg::cmd_t entry_q [2];
  logic          wptr_q, wptr_d;
  logic          rptr_q, rptr_d;
  logic [1:0]    cnt_q, cnt_d;

  // pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= cmd_i;
    end
  end

  assign cmd_o        = entry_q[rptr_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);

endmodule

// ===== design/shp_front.sv =====
`timescale 1ns / 1ps

module shp_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         init_done_i,
  shp_req_if.sink                      req,
  input  logic                         fifo_full_i,
  input  shp_pkg::rel_t                rel_i,
  output shp_pkg::cmd_t                cmd_o,
  output logic                         cmd_push_o,
  output logic                         kbuf_we_o,
  output logic [shp_pkg::KBUF_AW-1:0]  kbuf_waddr_o,
  output logic [7:0]                   kbuf_wdata_o
);

  logic [shp_pkg::LEN_W-1:0] len_q, len_d;
  logic                      ovf_q, ovf_d;
  logic [31:0]               hash_q, hash_d;
  logic                      bank_q, bank_d;
  logic [1:0]                busy_q, busy_d;

  logic                      accept;
  logic [7:0]                lc_byte;
  logic [31:0]               hash_mix;
  logic                      room;
  logic [shp_pkg::LEN_W-1:0] len_next;
  logic                      ovf_next;

  // a new key may only fill a bank the back end has released
  assign req.ready = init_done_i && !fifo_full_i && !busy_q[bank_q];
  assign accept    = req.valid && req.ready;

  // ascii lowercase and hash step
  assign lc_byte  = (req.key_byte >= 8'h41 && req.key_byte <= 8'h5A) ?
                    (req.key_byte + 8'h20) : req.key_byte;
  assign hash_mix = (hash_q ^ {24'd0, lc_byte}) * shp_pkg::HASH_PRIME;
  assign room     = (len_q < shp_pkg::LEN_W'(shp_pkg::MAX_KEY_BYTES));
  assign len_next = room ? (len_q + 7'd1) : len_q;
  assign ovf_next = ovf_q || !room;

  assign kbuf_waddr_o = {bank_q, len_q[shp_pkg::KEY_AW-1:0]};
  assign kbuf_wdata_o = lc_byte;

  // byte intake and command build
  always_comb begin
    len_d       = len_q;
    ovf_d       = ovf_q;
    hash_d      = hash_q;
    bank_d      = bank_q;
    busy_d      = busy_q;
    cmd_push_o  = 1'b0;
    kbuf_we_o   = 1'b0;
    cmd_o       = '0;
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (accept) begin
      case (req.mode)
        shp_pkg::MODE_CLEAR: begin
          cmd_push_o = 1'b1;
          cmd_o.clear = 1'b1;
          len_d  = '0;
          ovf_d  = 1'b0;
          hash_d = shp_pkg::HASH_BASIS;
        end
        shp_pkg::MODE_INSERT, shp_pkg::MODE_LOOKUP: begin
          kbuf_we_o = room;
          if (req.last) begin
            cmd_push_o     = 1'b1;
            cmd_o.lookup   = (req.mode == shp_pkg::MODE_LOOKUP);
            cmd_o.too_long = ovf_next;
            cmd_o.bank     = bank_q;
            cmd_o.len      = len_next;
            cmd_o.hash     = hash_mix;
            busy_d[bank_q] = 1'b1;
            bank_d = ~bank_q;
            len_d  = '0;
            ovf_d  = 1'b0;
            hash_d = shp_pkg::HASH_BASIS;
          end else begin
            len_d  = len_next;
            ovf_d  = ovf_next;
            hash_d = hash_mix;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      ovf_q  <= 1'b0;
      hash_q <= shp_pkg::HASH_BASIS;
      bank_q <= 1'b0;
      busy_q <= 2'b00;
    end else begin
      len_q  <= len_d;
      ovf_q  <= ovf_d;
      hash_q <= hash_d;
      bank_q <= bank_d;
      busy_q <= busy_d;
    end
  end

endmodule

// ===== design/shp_back.sv =====
`timescale 1ns / 1ps

module shp_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [shp_pkg::LG_W-1:0]     log2_cap_i,
  input  shp_pkg::cmd_t                cmd_i,
  input  logic                         fifo_empty_i,
  output logic                         pop_o,
  output shp_pkg::rel_t                rel_o,
  output logic                         init_done_o,
  output logic [shp_pkg::KBUF_AW-1:0]  kbuf_raddr_o,
  input  logic [7:0]                   kbuf_rdata_i,
  shp_rsp_if.source                    rsp
);

  localparam int unsigned SAW = shp_pkg::SLOT_AW;
  localparam int unsigned KAW = shp_pkg::KEY_AW;

  shp_pkg::back_state_e          state_q, state_d;
  shp_pkg::cmd_t                 cmd_q, cmd_d;
  logic [SAW-1:0]                idx_q, idx_d;
  logic [SAW-1:0]                cnt_q, cnt_d;
  logic [SAW-1:0]                mask_q, mask_d;
  logic [SAW-1:0]                sweep_q, sweep_d;
  logic [shp_pkg::LEN_W-1:0]     ptr_q, ptr_d;
  logic                          chk_q, chk_d;
  logic [KAW-1:0]                chk_idx_q, chk_idx_d;
  logic [shp_pkg::CNT_W-1:0]     count_q, count_d;
  shp_pkg::res_t                 res_q, res_d;
  logic                          rvalid_q, rvalid_d;

  logic [shp_pkg::LG_W-1:0]      lg_c;
  logic [SAW-1:0]                mask_c;
  logic                          meta_we;
  logic [SAW-1:0]                meta_waddr;
  logic [shp_pkg::META_W-1:0]    meta_wdata;
  logic [shp_pkg::META_W-1:0]    meta_rdata;
  logic                          sb_we;
  logic [7:0]                    sb_rdata;
  logic                          issue;
  logic                          last_chk;
  logic                          adv;
  logic                          hit;

  // slot metadata: valid bit and key length
  shp_ram #(
    .WIDTH (shp_pkg::META_W),
    .DEPTH (shp_pkg::SLOTS)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .raddr_i (idx_q),
    .rdata_o (meta_rdata)
  );

  // stored key bytes, one row of bytes per slot
  shp_ram #(
    .WIDTH (8),
    .DEPTH (shp_pkg::SBYTES_DEPTH)
  ) u_bytes_ram (
    .clk_i   (clk_i),
    .we_i    (sb_we),
    .waddr_i ({idx_q, chk_idx_q}),
    .wdata_i (kbuf_rdata_i),
    .raddr_i ({idx_q, ptr_q[KAW-1:0]}),
    .rdata_o (sb_rdata)
  );

  // capacity clamp
  always_comb begin
    lg_c = log2_cap_i;
    if (log2_cap_i < shp_pkg::LG_MIN) begin
      lg_c = shp_pkg::LG_MIN;
    end else if (log2_cap_i > shp_pkg::LG_MAX) begin
      lg_c = shp_pkg::LG_MAX;
    end
    mask_c = SAW'((shp_pkg::CNT_W'(1) << lg_c) - shp_pkg::CNT_W'(1));
  end

  // byte stream over the key: one read issued per cycle, used in the cycle after
  assign issue        = (state_q == shp_pkg::B_CMP || state_q == shp_pkg::B_COPY) &&
                        (ptr_q < cmd_q.len);
  assign kbuf_raddr_o = {cmd_q.bank, ptr_q[KAW-1:0]};
  assign last_chk     = ({1'b0, chk_idx_q} == (cmd_q.len - 7'd1));

  assign init_done_o = (state_q != shp_pkg::B_INIT);

  // probe sequencer
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    mask_d     = mask_q;
    sweep_d    = sweep_q;
    ptr_d      = issue ? (ptr_q + 7'd1) : ptr_q;
    chk_d      = issue;
    chk_idx_d  = issue ? ptr_q[KAW-1:0] : chk_idx_q;
    count_d    = count_q;
    res_d      = res_q;
    rvalid_d   = rvalid_q;
    pop_o      = 1'b0;
    rel_o      = '0;
    meta_we    = 1'b0;
    meta_waddr = idx_q;
    meta_wdata = '0;
    sb_we      = 1'b0;
    adv        = 1'b0;
    hit        = 1'b0;

    case (state_q)
      shp_pkg::B_INIT, shp_pkg::B_SWEEP: begin
        meta_we    = 1'b1;
        meta_waddr = sweep_q;
        sweep_d    = sweep_q + SAW'(1);
        if (sweep_q == SAW'(shp_pkg::SLOTS - 1)) begin
          if (state_q == shp_pkg::B_INIT) begin
            state_d = shp_pkg::B_IDLE;
          end else begin
            count_d  = '0;
            res_d    = '0;
            rvalid_d = 1'b1;
            state_d  = shp_pkg::B_RESULT;
          end
        end
      end
      shp_pkg::B_IDLE: begin
        if (!fifo_empty_i) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          if (cmd_i.clear) begin
            sweep_d = '0;
            state_d = shp_pkg::B_SWEEP;
          end else if (cmd_i.too_long) begin
            res_d = '0;
            res_d.key_too_long = 1'b1;
            res_d.key_count    = count_q;
            rvalid_d = 1'b1;
            state_d  = shp_pkg::B_RESULT;
          end else begin
            mask_d  = mask_c;
            idx_d   = cmd_i.hash[SAW-1:0] & mask_c;
            cnt_d   = '0;
            state_d = shp_pkg::B_META;
          end
        end
      end
      shp_pkg::B_META: begin
        state_d = shp_pkg::B_CHECK;
      end
      shp_pkg::B_CHECK: begin
        if (!meta_rdata[shp_pkg::META_W-1]) begin
          if (cmd_q.lookup) begin
            res_d = '0;
            res_d.key_count = count_q;
            rvalid_d = 1'b1;
            state_d  = shp_pkg::B_RESULT;
          end else begin
            meta_we    = 1'b1;
            meta_wdata = {1'b1, cmd_q.len};
            if (cmd_q.len == '0) begin
              count_d = count_q + shp_pkg::CNT_W'(1);
              res_d = '0;
              res_d.inserted  = 1'b1;
              res_d.key_count = count_q + shp_pkg::CNT_W'(1);
              rvalid_d = 1'b1;
              state_d  = shp_pkg::B_RESULT;
            end else begin
              ptr_d   = '0;
              chk_d   = 1'b0;
              state_d = shp_pkg::B_COPY;
            end
          end
        end else if (meta_rdata[shp_pkg::LEN_W-1:0] == cmd_q.len) begin
          if (cmd_q.len == '0) begin
            hit = 1'b1;
          end else begin
            ptr_d   = '0;
            chk_d   = 1'b0;
            state_d = shp_pkg::B_CMP;
          end
        end else begin
          adv = 1'b1;
        end
      end
      shp_pkg::B_CMP: begin
        if (chk_q) begin
          if (kbuf_rdata_i != sb_rdata) begin
            adv = 1'b1;
          end else if (last_chk) begin
            hit = 1'b1;
          end
        end
      end
      shp_pkg::B_COPY: begin
        if (chk_q) begin
          sb_we = 1'b1;
          if (last_chk) begin
            count_d = count_q + shp_pkg::CNT_W'(1);
            res_d = '0;
            res_d.inserted  = 1'b1;
            res_d.key_count = count_q + shp_pkg::CNT_W'(1);
            rvalid_d = 1'b1;
            state_d  = shp_pkg::B_RESULT;
          end
        end
      end
      shp_pkg::B_RESULT: begin
        if (rsp.ready) begin
          rvalid_d = 1'b0;
          state_d  = shp_pkg::B_IDLE;
          if (!cmd_q.clear) begin
            rel_o.valid = 1'b1;
            rel_o.bank  = cmd_q.bank;
          end
        end
      end
      default: begin
        state_d = shp_pkg::B_IDLE;
      end
    endcase

    // key matched a stored slot
    if (hit) begin
      res_d = '0;
      res_d.found     = cmd_q.lookup;
      res_d.duplicate = !cmd_q.lookup;
      res_d.key_count = count_q;
      rvalid_d = 1'b1;
      state_d  = shp_pkg::B_RESULT;
    end

    // move to the next slot, or stop after a full wrap
    if (adv) begin
      if (cnt_q == mask_q) begin
        res_d = '0;
        res_d.table_full = !cmd_q.lookup;
        res_d.key_count  = count_q;
        rvalid_d = 1'b1;
        state_d  = shp_pkg::B_RESULT;
      end else begin
        idx_d   = (idx_q + SAW'(1)) & mask_q;
        cnt_d   = cnt_q + SAW'(1);
        state_d = shp_pkg::B_META;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= shp_pkg::B_INIT;
      sweep_q  <= '0;
      count_q  <= '0;
      rvalid_q <= 1'b0;
      chk_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      sweep_q  <= sweep_d;
      count_q  <= count_d;
      rvalid_q <= rvalid_d;
      chk_q    <= chk_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    idx_q     <= idx_d;
    cnt_q     <= cnt_d;
    mask_q    <= mask_d;
    ptr_q     <= ptr_d;
    chk_idx_q <= chk_idx_d;
    res_q     <= res_d;
  end

  assign rsp.valid        = rvalid_q;
  assign rsp.found        = res_q.found;
  assign rsp.inserted     = res_q.inserted;
  assign rsp.duplicate    = res_q.duplicate;
  assign rsp.table_full   = res_q.table_full;
  assign rsp.key_too_long = res_q.key_too_long;
  assign rsp.key_count    = res_q.key_count;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import shp_pkg::*;

  logic clk;
  logic rst_n;

  shp_req_if req();
  shp_rsp_if rsp();
  shp_cfg_if cfg();

  string_hash_set_probe_core i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req),
    .rsp_o  (rsp),
    .cfg_i  (cfg)
  );

  localparam logic [1:0] MODE_IGNORED = 2'd3;
  localparam int unsigned DRAIN_CYCLES = 2100;

  // clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the key set
  logic [7:0]       pend_bytes [MAX_KEY_BYTES];
  int unsigned      pend_len;
  logic             pend_ovf;
  logic [31:0]      pend_hash;
  bit               set_used  [SLOTS];
  int unsigned      set_len   [SLOTS];
  logic [7:0]       set_bytes [SLOTS][MAX_KEY_BYTES];
  int unsigned      set_count;
  logic [LG_W-1:0]  cur_lg;

  res_t        expected_rsp_q [$];
  int unsigned errors = 0;
  int unsigned items_sent;

  function automatic bit slot_holds_key(int unsigned idx);
    if (set_len[idx] != pend_len) return 1'b0;
    for (int unsigned k = 0; k < pend_len; k++)
      if (set_bytes[idx][k] != pend_bytes[k]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void restart_key();
    pend_len  = 0;
    pend_ovf  = 1'b0;
    pend_hash = HASH_BASIS;
  endfunction

  // update the shadow set for one accepted item, return the result it causes
  function automatic bit set_step(logic [1:0] mode, logic [7:0] kb, logic lst,
                                  output res_t res);
    int unsigned lg;
    int unsigned cap;
    int unsigned start;
    int unsigned idx;
    int unsigned free_idx;
    bit          hit;
    bit          have_free;
    logic [7:0]  b;
    res = '0;
    hit = 1'b0;
    have_free = 1'b0;
    free_idx = 0;
    if (mode == MODE_IGNORED) return 1'b0;
    if (mode == MODE_CLEAR) begin
      for (int unsigned s = 0; s < SLOTS; s++) set_used[s] = 1'b0;
      set_count = 0;
      restart_key();
      res.key_count = '0;
      return 1'b1;
    end
    b = kb;
    if (b >= 8'h41 && b <= 8'h5a) b = b + 8'h20;
    pend_hash = (pend_hash ^ {24'd0, b}) * HASH_PRIME;
    if (pend_len < MAX_KEY_BYTES) begin
      pend_bytes[pend_len] = b;
      pend_len++;
    end else begin
      pend_ovf = 1'b1;
    end
    if (!lst) return 1'b0;
    if (pend_ovf) begin
      res.key_too_long = 1'b1;
    end else begin
      lg = int'(cur_lg);
      if (lg < LG_MIN) lg = LG_MIN;
      if (lg > LG_MAX) lg = LG_MAX;
      cap = 1 << lg;
      if (cap > SLOTS) cap = SLOTS;
      start = pend_hash % cap;
      for (int unsigned i = 0; i < cap; i++) begin
        idx = (start + i) % cap;
        if (!set_used[idx]) begin
          have_free = 1'b1;
          free_idx = idx;
          break;
        end
        if (slot_holds_key(idx)) begin
          hit = 1'b1;
          break;
        end
      end
      if (mode == MODE_LOOKUP) begin
        res.found = hit;
      end else if (hit) begin
        res.duplicate = 1'b1;
      end else if (have_free) begin
        set_used[free_idx] = 1'b1;
        set_len[free_idx] = pend_len;
        for (int unsigned k = 0; k < pend_len; k++) set_bytes[free_idx][k] = pend_bytes[k];
        set_count++;
        res.inserted = 1'b1;
      end else begin
        res.table_full = 1'b1;
      end
    end
    restart_key();
    res.key_count = (set_count > 2047) ? 11'd2047 : set_count[CNT_W-1:0];
    return 1'b1;
  endfunction

  // sender with bursts and gaps
  int unsigned burst_left;

  task automatic send_item(logic [1:0] mode, logic [7:0] kb, logic lst,
                           bit use_typed, res_t typed);
    res_t r;
    if (burst_left == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 15);
    end
    req.valid    <= 1'b1;
    req.mode     <= mode;
    req.key_byte <= kb;
    req.last     <= lst;
    do @(posedge clk); while (!req.ready);
    burst_left--;
    items_sent++;
    if (set_step(mode, kb, lst, r))
      expected_rsp_q.push_back(use_typed ? typed : r);
  endtask

  task automatic wait_idle();
    req.valid <= 1'b0;
    burst_left = 0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [LG_W-1:0] lg);
    cfg.valid         <= 1'b1;
    cfg.log2_capacity <= lg;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    cur_lg = lg;
  endtask

  // receiver stall pattern and result check
  int unsigned stall_style = 0;
  int unsigned stall_cnt = 0;
  res_t        got;
  res_t        want;

  always @(posedge clk) begin
    if (rst_n && rsp.valid && rsp.ready) begin
      got.found        = rsp.found;
      got.inserted     = rsp.inserted;
      got.duplicate    = rsp.duplicate;
      got.table_full   = rsp.table_full;
      got.key_too_long = rsp.key_too_long;
      got.key_count    = rsp.key_count;
      if (expected_rsp_q.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        want = expected_rsp_q.pop_front();
        if (got.found != want.found) begin
          $error("found: expected %0d actual %0d", want.found, got.found); errors++;
        end
        if (got.inserted != want.inserted) begin
          $error("inserted: expected %0d actual %0d", want.inserted, got.inserted); errors++;
        end
        if (got.duplicate != want.duplicate) begin
          $error("duplicate: expected %0d actual %0d", want.duplicate, got.duplicate);
          errors++;
        end
        if (got.table_full != want.table_full) begin
          $error("table_full: expected %0d actual %0d", want.table_full, got.table_full);
          errors++;
        end
        if (got.key_too_long != want.key_too_long) begin
          $error("key_too_long: expected %0d actual %0d", want.key_too_long,
                 got.key_too_long);
          errors++;
        end
        if (got.key_count != want.key_count) begin
          $error("key_count: expected %0d actual %0d", want.key_count,
                 got.key_count);
          errors++;
        end
      end
    end
    // new stall style picked at random
    stall_cnt++;
    if (stall_cnt % 64 == 0) stall_style = $urandom_range(0, 3);
    case (stall_style)
      0: rsp.ready <= 1'b1;
      1: rsp.ready <= ($urandom_range(0, 1) == 1);
      2: rsp.ready <= ($urandom_range(0, 5) == 0);
      default: rsp.ready <= (stall_cnt % 8) < 3;
    endcase
  end

  // directed stimulus table
  typedef struct {
    logic [1:0]  mode;
    logic [7:0]  kb;
    logic        lst;
    int unsigned reps;
    bit          typed;
    res_t        res;
  } stim_row_t;

  localparam res_t R_NONE = '0;

  stim_row_t directed [] = '{
    '{MODE_LOOKUP, 8'h61, 1'b1, 1, 1'b1, R_NONE},
    '{MODE_INSERT, 8'h61, 1'b1, 1, 1'b0, R_NONE},
    '{MODE_LOOKUP, 8'h41, 1'b1, 1, 1'b0, R_NONE},
    '{MODE_INSERT, 8'h41, 1'b1, 1, 1'b0, R_NONE},
    '{MODE_INSERT, 8'h00, 1'b0, 1, 1'b0, R_NONE},
    '{MODE_INSERT, 8'h00, 1'b1, 1, 1'b0, R_NONE},
    '{MODE_LOOKUP, 8'h00, 1'b1, 2, 1'b0, R_NONE},
    '{MODE_IGNORED, 8'hff, 1'b1, 1, 1'b0, R_NONE},
    '{MODE_LOOKUP, 8'h7a, 1'b0, 1, 1'b0, R_NONE},
    '{MODE_INSERT, 8'h5a, 1'b1, 1, 1'b0, R_NONE},
    '{MODE_INSERT, 8'hff, 1'b1, 64, 1'b0, R_NONE},
    '{MODE_LOOKUP, 8'hff, 1'b1, 64, 1'b0, R_NONE},
    '{MODE_INSERT, 8'h80, 1'b1, 65, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 11'd4}},
    '{MODE_LOOKUP, 8'h41, 1'b1, 70, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 11'd4}},
    '{MODE_CLEAR, 8'h00, 1'b0, 1, 1'b1, R_NONE},
    '{MODE_LOOKUP, 8'h61, 1'b1, 1, 1'b1, R_NONE},
    '{MODE_INSERT, 8'h51, 1'b0, 1, 1'b0, R_NONE},
    '{MODE_CLEAR, 8'hff, 1'b1, 1, 1'b1, R_NONE},
    '{MODE_LOOKUP, 8'h71, 1'b1, 1, 1'b1, R_NONE}
  };

  logic [LG_W-1:0] phase_lg [] = '{4'd1, 4'd0, 4'd2, 4'd15, 4'd3, 4'd11, 4'd4, 4'd10};

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h61;
      1: return 8'h41;
      2: return 8'h62;
      3: return 8'h42;
      4: return 8'h00;
      5: return 8'h63;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_key();
    int unsigned len;
    logic [1:0]  fmode;
    if ($urandom_range(0, 15) == 0) len = $urandom_range(60, 70);
    else len = $urandom_range(1, 3);
    fmode = $urandom_range(0, 1) ? MODE_LOOKUP : MODE_INSERT;
    for (int unsigned k = 0; k < len; k++) begin
      if (k + 1 == len) send_item(fmode, pick_byte(), 1'b1, 1'b0, R_NONE);
      else send_item($urandom_range(0, 3) == 0 ? ~fmode & 2'd1 : fmode,
                     pick_byte(), 1'b0, 1'b0, R_NONE);
    end
  endtask

  // main sequence
  initial begin
    items_sent = 0;
    burst_left = 0;
    for (int unsigned s = 0; s < SLOTS; s++) set_used[s] = 1'b0;
    set_count = 0;
    cur_lg = LG_RESET;
    restart_key();
    rst_n <= 1'b0;
    req.valid <= 1'b0;
    req.mode <= MODE_INSERT;
    req.key_byte <= 8'h00;
    req.last <= 1'b0;
    cfg.valid <= 1'b0;
    cfg.log2_capacity <= LG_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      for (int unsigned r = 0; r < directed[i].reps; r++)
        send_item(directed[i].mode, directed[i].kb,
                  (r + 1 == directed[i].reps) ? directed[i].lst : 1'b0,
                  directed[i].typed && (r + 1 == directed[i].reps), directed[i].res);
    end

    foreach (phase_lg[p]) begin
      wait_idle();
      write_capacity(phase_lg[p]);
      items_sent = 0;
      while (items_sent < 85) begin
        case ($urandom_range(0, 39))
          0: send_item(MODE_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                       1'b0, R_NONE);
          1: send_item(MODE_IGNORED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                       1'b0, R_NONE);
          default: random_key();
        endcase
      end
    end

    wait_idle();
    if (errors == 0) $display("string_hash_set_probe_core test passed");
    else $display("string_hash_set_probe_core test failed");
    $finish;
  end

  // run limit
  initial begin
    #40000000;
    $display("string_hash_set_probe_core test failed");
    $finish;
  end

endmodule
